// ===== rtl/bllca_pkg.sv =====
package bllca_pkg;

  localparam int FIELD_W = 10;
  localparam int FUNC_W = 2;
  localparam int PC_W = 5;

  localparam int DEF_NODES = 1024;
  localparam int DEF_LEVELS = 10;

  // operation codes on func
  localparam logic [FUNC_W-1:0] FN_LOAD = 2'd0;
  localparam logic [FUNC_W-1:0] FN_BUILD = 2'd1;
  localparam logic [FUNC_W-1:0] FN_QUERY = 2'd2;

  // jump table read address select
  localparam logic [2:0] JRA_A_LVL = 3'd0;
  localparam logic [2:0] JRA_B_LVL = 3'd1;
  localparam logic [2:0] JRA_A_L0 = 3'd2;
  localparam logic [2:0] JRA_IDX_LO = 3'd3;
  localparam logic [2:0] JRA_Q_LO = 3'd4;

  // jump table write select
  localparam logic [1:0] JWR_NONE = 2'd0;
  localparam logic [1:0] JWR_LOAD = 2'd1;
  localparam logic [1:0] JWR_BUILD = 2'd2;

  // depth store read address select
  localparam logic [1:0] DRA_A = 2'd0;
  localparam logic [1:0] DRA_B = 2'd1;
  localparam logic [1:0] DRA_Q = 2'd2;

  // level counter ops
  localparam logic [2:0] LV_HOLD = 3'd0;
  localparam logic [2:0] LV_TOP = 3'd1;
  localparam logic [2:0] LV_ONE = 3'd2;
  localparam logic [2:0] LV_DEC = 3'd3;
  localparam logic [2:0] LV_INC = 3'd4;

  // node index counter ops
  localparam logic [1:0] IX_HOLD = 2'd0;
  localparam logic [1:0] IX_CLR = 2'd1;
  localparam logic [1:0] IX_INC = 2'd2;

  // result source
  localparam logic [1:0] EM_NONE = 2'd0;
  localparam logic [1:0] EM_A = 2'd1;
  localparam logic [1:0] EM_Q = 2'd2;

  // branch conditions
  localparam logic [2:0] CD_NEVER = 3'd0;
  localparam logic [2:0] CD_NO_LIFT = 3'd1;
  localparam logic [2:0] CD_LVL_NZ = 3'd2;
  localparam logic [2:0] CD_A_EQ_B = 3'd3;
  localparam logic [2:0] CD_IDX_NLAST = 3'd4;
  localparam logic [2:0] CD_LVL_NTOP = 3'd5;
  localparam logic [2:0] CD_ONE_LEVEL = 3'd6;

  // program steps
  localparam logic [PC_W-1:0] ST_LOAD = 5'd0;
  localparam logic [PC_W-1:0] ST_B0 = 5'd1;
  localparam logic [PC_W-1:0] ST_B1 = 5'd2;
  localparam logic [PC_W-1:0] ST_B2 = 5'd3;
  localparam logic [PC_W-1:0] ST_B3 = 5'd4;
  localparam logic [PC_W-1:0] ST_B4 = 5'd5;
  localparam logic [PC_W-1:0] ST_END = 5'd6;
  localparam logic [PC_W-1:0] ST_Q0 = 5'd7;
  localparam logic [PC_W-1:0] ST_Q1 = 5'd8;
  localparam logic [PC_W-1:0] ST_Q2 = 5'd9;
  localparam logic [PC_W-1:0] ST_Q3 = 5'd10;
  localparam logic [PC_W-1:0] ST_L1A = 5'd11;
  localparam logic [PC_W-1:0] ST_L1B = 5'd12;
  localparam logic [PC_W-1:0] ST_L1C = 5'd13;
  localparam logic [PC_W-1:0] ST_L1D = 5'd14;
  localparam logic [PC_W-1:0] ST_P0 = 5'd15;
  localparam logic [PC_W-1:0] ST_P1 = 5'd16;
  localparam logic [PC_W-1:0] ST_P2 = 5'd17;
  localparam logic [PC_W-1:0] ST_P3 = 5'd18;
  localparam logic [PC_W-1:0] ST_P4 = 5'd19;
  localparam logic [PC_W-1:0] ST_P5 = 5'd20;
  localparam logic [PC_W-1:0] ST_EA = 5'd21;

  typedef struct packed {
    logic [2:0]      jt_ra;
    logic [1:0]      jt_wr;
    logic [1:0]      dp_ra;
    logic            dp_we;
    logic            da_ld;
    logic            db_ld;
    logic            a_from_q;
    logic            swap;
    logic            pa_ld;
    logic            upd;
    logic [2:0]      lvl_op;
    logic [1:0]      idx_op;
    logic [1:0]      emit;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
    logic            fin;
  } ctrl_t;

  typedef struct packed {
    logic no_lift;
    logic lvl_nz;
    logic a_eq_b;
    logic idx_nlast;
    logic lvl_ntop;
    logic one_level;
  } stat_t;

  localparam ctrl_t CTRL_NOP = '{default: '0};

  function automatic logic [PC_W-1:0] entry_pc(input logic [FUNC_W-1:0] f);
    logic [PC_W-1:0] p;
    case (f)
      FN_LOAD: p = ST_LOAD;
      FN_BUILD: p = ST_B0;
      default: p = ST_Q0;
    endcase
    return p;
  endfunction

  // control store
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = CTRL_NOP;
    case (pc)
      ST_LOAD: begin
        w.jt_wr = JWR_LOAD;
        w.dp_we = 1'b1;
        w.fin = 1'b1;
      end
      ST_B0: begin
        w.lvl_op = LV_ONE;
        w.idx_op = IX_CLR;
        w.cond = CD_ONE_LEVEL;
        w.target = ST_END;
      end
      ST_B1: w.jt_ra = JRA_IDX_LO;
      ST_B2: w.jt_ra = JRA_Q_LO;
      ST_B3: begin
        w.jt_wr = JWR_BUILD;
        w.idx_op = IX_INC;
        w.cond = CD_IDX_NLAST;
        w.target = ST_B1;
      end
      ST_B4: begin
        w.lvl_op = LV_INC;
        w.cond = CD_LVL_NTOP;
        w.target = ST_B1;
      end
      ST_END: w.fin = 1'b1;
      ST_Q0: w.dp_ra = DRA_A;
      ST_Q1: begin
        w.dp_ra = DRA_B;
        w.da_ld = 1'b1;
      end
      ST_Q2: w.db_ld = 1'b1;
      ST_Q3: begin
        w.swap = 1'b1;
        w.lvl_op = LV_TOP;
      end
      ST_L1A: begin
        w.jt_ra = JRA_A_LVL;
        w.cond = CD_NO_LIFT;
        w.target = ST_L1D;
      end
      ST_L1B: begin
        w.a_from_q = 1'b1;
        w.dp_ra = DRA_Q;
      end
      ST_L1C: w.da_ld = 1'b1;
      ST_L1D: begin
        w.lvl_op = LV_DEC;
        w.cond = CD_LVL_NZ;
        w.target = ST_L1A;
      end
      ST_P0: begin
        w.lvl_op = LV_TOP;
        w.cond = CD_A_EQ_B;
        w.target = ST_EA;
      end
      ST_P1: w.jt_ra = JRA_A_LVL;
      ST_P2: begin
        w.jt_ra = JRA_B_LVL;
        w.pa_ld = 1'b1;
      end
      ST_P3: begin
        w.upd = 1'b1;
        w.lvl_op = LV_DEC;
        w.cond = CD_LVL_NZ;
        w.target = ST_P1;
      end
      ST_P4: w.jt_ra = JRA_A_L0;
      ST_P5: begin
        w.emit = EM_Q;
        w.fin = 1'b1;
      end
      ST_EA: begin
        w.emit = EM_A;
        w.fin = 1'b1;
      end
      default: w = CTRL_NOP;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/bllca_ram.sv =====
module bllca_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bllca_seq.sv =====
module bllca_seq
  import bllca_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [FUNC_W-1:0] func,
  input  stat_t             stat,
  output ctrl_t             cw,
  output logic              busy
);

  logic [PC_W-1:0] pc;
  logic            running;
  ctrl_t           word;
  logic            taken;

  assign word = ucode(pc);
  assign cw = running ? word : CTRL_NOP;
  assign busy = running;

  always_comb begin
    case (word.cond)
      CD_NO_LIFT: taken = stat.no_lift;
      CD_LVL_NZ: taken = stat.lvl_nz;
      CD_A_EQ_B: taken = stat.a_eq_b;
      CD_IDX_NLAST: taken = stat.idx_nlast;
      CD_LVL_NTOP: taken = stat.lvl_ntop;
      CD_ONE_LEVEL: taken = stat.one_level;
      default: taken = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      pc <= ST_LOAD;
    end else if (accept) begin
      // unused function code starts nothing
      running <= (func == FN_LOAD) || (func == FN_BUILD) || (func == FN_QUERY);
      pc <= entry_pc(func);
    end else if (running) begin
      if (word.fin) begin
        running <= 1'b0;
      end else if (taken) begin
        pc <= word.target;
      end else begin
        pc <= pc + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/bllca_dp.sv =====
module bllca_dp
  import bllca_pkg::*;
#(
  parameter int NODES = DEF_NODES,
  parameter int LEVELS = DEF_LEVELS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [FUNC_W-1:0]  func,
  input  logic [FIELD_W-1:0] node,
  input  logic [FIELD_W-1:0] parent,
  input  logic [FIELD_W-1:0] depth,
  input  logic [FIELD_W-1:0] other_node,
  input  ctrl_t              cw,
  output stat_t              stat,
  output logic [FIELD_W-1:0] ancestor,
  output logic               done
);

  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int JD = LEVELS * NODES;
  localparam int AW = (JD > 1) ? $clog2(JD) : 1;
  localparam logic [LW-1:0] LVL_TOP = LW'(LEVELS - 1);
  localparam logic [NW-1:0] IDX_LAST = NW'(NODES - 1);
  localparam int CW = FIELD_W + 7;

  // input index modulo node count, by conditional subtraction
  function automatic logic [NW-1:0] wrap(input logic [FIELD_W-1:0] v);
    logic [26:0] r;
    logic [26:0] m;
    r = 27'(v);
    for (int s = FIELD_W - 1; s >= 0; s--) begin
      m = 27'(NODES) << s;
      if (r >= m) begin
        r = r - m;
      end
    end
    return NW'(r);
  endfunction

  function automatic logic [AW-1:0] jaddr(input logic [LW-1:0] l, input logic [NW-1:0] n);
    return AW'(int'(l) * NODES + int'(n));
  endfunction

  logic [NW-1:0]      a, a_next;
  logic [NW-1:0]      b, b_next;
  logic [NW-1:0]      pa;
  logic [FIELD_W-1:0] da, da_next;
  logic [FIELD_W-1:0] db, db_next;
  logic [LW-1:0]      lvl;
  logic [LW-1:0]      lvl_lo;
  logic [NW-1:0]      idx;

  logic [AW-1:0]      jt_raddr, jt_waddr;
  logic [NW-1:0]      jt_wdata, jt_q;
  logic               jt_we;
  logic [NW-1:0]      dp_raddr;
  logic [FIELD_W-1:0] dp_q;

  logic               do_swap, do_upd;
  logic [CW-1:0]      lift_lhs, lift_rhs;

  assign lvl_lo = lvl - 1'b1;

  always_comb begin
    case (cw.jt_ra)
      JRA_A_LVL: jt_raddr = jaddr(lvl, a);
      JRA_B_LVL: jt_raddr = jaddr(lvl, b);
      JRA_IDX_LO: jt_raddr = jaddr(lvl_lo, idx);
      JRA_Q_LO: jt_raddr = jaddr(lvl_lo, jt_q);
      default: jt_raddr = jaddr('0, a);
    endcase
  end

  always_comb begin
    case (cw.jt_wr)
      JWR_LOAD: begin
        jt_we = 1'b1;
        jt_waddr = jaddr('0, a);
        jt_wdata = b;
      end
      JWR_BUILD: begin
        jt_we = 1'b1;
        jt_waddr = jaddr(lvl, idx);
        jt_wdata = jt_q;
      end
      default: begin
        jt_we = 1'b0;
        jt_waddr = jaddr(lvl, idx);
        jt_wdata = jt_q;
      end
    endcase
  end

  always_comb begin
    case (cw.dp_ra)
      DRA_B: dp_raddr = b;
      DRA_Q: dp_raddr = jt_q;
      default: dp_raddr = a;
    endcase
  end

  bllca_ram #(.WIDTH(NW), .DEPTH(JD)) u_jt (
    .clk   (clk),
    .we    (jt_we),
    .waddr (jt_waddr),
    .wdata (jt_wdata),
    .raddr (jt_raddr),
    .rdata (jt_q)
  );

  bllca_ram #(.WIDTH(FIELD_W), .DEPTH(NODES)) u_depth (
    .clk   (clk),
    .we    (cw.dp_we),
    .waddr (a),
    .wdata (da),
    .raddr (dp_raddr),
    .rdata (dp_q)
  );

  // lift while depth difference reaches 2^lvl
  assign lift_lhs = CW'(da);
  assign lift_rhs = CW'(db) + (CW'(1) << lvl);

  assign stat.no_lift = lift_lhs < lift_rhs;
  assign stat.lvl_nz = lvl != '0;
  assign stat.a_eq_b = a == b;
  assign stat.idx_nlast = idx != IDX_LAST;
  assign stat.lvl_ntop = lvl != LVL_TOP;
  assign stat.one_level = LEVELS == 1;

  assign do_swap = cw.swap && (da < db);
  assign do_upd = cw.upd && (pa != jt_q);

  always_comb begin
    a_next = a;
    b_next = b;
    da_next = da;
    db_next = db;
    if (accept) begin
      a_next = wrap(node);
      b_next = (func == FN_LOAD) ? wrap(parent) : wrap(other_node);
      da_next = depth;
    end else begin
      if (cw.a_from_q) begin
        a_next = jt_q;
      end else if (do_swap) begin
        a_next = b;
        b_next = a;
        da_next = db;
        db_next = da;
      end else if (do_upd) begin
        a_next = pa;
        b_next = jt_q;
      end
      if (cw.da_ld) begin
        da_next = dp_q;
      end
      if (cw.db_ld) begin
        db_next = dp_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    a <= a_next;
    b <= b_next;
    da <= da_next;
    db <= db_next;
    if (cw.pa_ld) begin
      pa <= jt_q;
    end
    case (cw.lvl_op)
      LV_TOP: lvl <= LVL_TOP;
      LV_ONE: lvl <= LW'(1);
      LV_DEC: lvl <= lvl - 1'b1;
      LV_INC: lvl <= lvl + 1'b1;
      default: lvl <= lvl;
    endcase
    case (cw.idx_op)
      IX_CLR: idx <= '0;
      IX_INC: idx <= (idx == IDX_LAST) ? '0 : idx + 1'b1;
      default: idx <= idx;
    endcase
    if (cw.emit == EM_A) begin
      ancestor <= FIELD_W'(a);
    end else if (cw.emit == EM_Q) begin
      ancestor <= FIELD_W'(jt_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cw.emit != EM_NONE;
    end
  end

endmodule

// ===== rtl/binary_lifting_lca_engine_top.sv =====
// lowest common ancestor engine, binary lifting, microcoded control
// load, build and query run as sequences of microcode steps;
// a query strobes its result on done, and its step sequence is
// set by the single read port of the jump table memory (one read per step)
// one transaction at a time, the next start is taken once busy falls; the receiver cannot stall
// rst clears the sequencer and the result strobe; memories hold no reset value
module binary_lifting_lca_engine_top
  import bllca_pkg::*;
#(
  parameter int NODES = DEF_NODES,
  parameter int LEVELS = DEF_LEVELS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [FUNC_W-1:0]  func,
  input  logic [FIELD_W-1:0] node,
  input  logic [FIELD_W-1:0] parent,
  input  logic [FIELD_W-1:0] depth,
  input  logic [FIELD_W-1:0] other_node,
  output logic [FIELD_W-1:0] ancestor,
  output logic               done
);

  // a transaction is taken when start meets an idle engine
  logic  accept;
  ctrl_t cw;
  stat_t stat;

  assign accept = start && !busy;

  // sequencer: step counter, control store, conditional jumps
  bllca_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .func   (func),
    .stat   (stat),
    .cw     (cw),
    .busy   (busy)
  );

  // datapath: node and depth registers, counters, jump table and depth memories;
  // the result goes out through a register and strobes done for one cycle
  bllca_dp #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .func       (func),
    .node       (node),
    .parent     (parent),
    .depth      (depth),
    .other_node (other_node),
    .cw         (cw),
    .stat       (stat),
    .ancestor   (ancestor),
    .done       (done)
  );

endmodule

// ===== verif/lca_checker.sv =====
`timescale 1ns / 1ps
module lca_checker
  import bllca_pkg::*;
#(
  parameter int NODES = DEF_NODES,
  parameter int LEVELS = DEF_LEVELS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [FUNC_W-1:0]  func,
  input  logic [FIELD_W-1:0] node,
  input  logic [FIELD_W-1:0] parent,
  input  logic [FIELD_W-1:0] depth,
  input  logic [FIELD_W-1:0] other_node,
  input  logic [FIELD_W-1:0] ancestor,
  input  logic               done,
  output int                 failures,
  output int                 pending
);

  // shadow of the ancestor table and the depth memory
  logic [FIELD_W-1:0] hop_tbl [LEVELS][NODES];
  logic [FIELD_W-1:0] depth_mem [NODES];
  logic [FIELD_W-1:0] lca_expect [$];
  int unsigned        answers_seen;

  initial begin
    failures = 0;
    pending = 0;
    answers_seen = 0;
  end

  task automatic report_miss(input string what);
    $display("[%0t] lca mismatch: %s", $time, what);
    failures++;
  endtask

  task automatic clear_shadow();
    for (int k = 0; k < LEVELS; k++) begin
      for (int i = 0; i < NODES; i++) begin
        hop_tbl[k][i] = '0;
      end
    end
    for (int i = 0; i < NODES; i++) begin
      depth_mem[i] = '0;
    end
  endtask

  // level k of node i is level k-1 of its level k-1 ancestor
  task automatic rebuild_hops();
    for (int k = 1; k < LEVELS; k++) begin
      for (int i = 0; i < NODES; i++) begin
        hop_tbl[k][i] = hop_tbl[k-1][hop_tbl[k-1][i] % NODES];
      end
    end
  endtask

  function automatic logic [FIELD_W-1:0] lca_of(input int unsigned x, input int unsigned y);
    int unsigned a;
    int unsigned b;
    int unsigned t;
    int unsigned pa;
    int unsigned pb;
    int          gap;
    int          lv;
    a = x % NODES;
    b = y % NODES;
    if (depth_mem[a] < depth_mem[b]) begin
      t = a;
      a = b;
      b = t;
    end
    // depths are looked up again at every level
    for (lv = LEVELS - 1; lv >= 0; lv--) begin
      gap = int'(depth_mem[a]) - int'(depth_mem[b]);
      if (gap >= (1 << lv)) begin
        a = hop_tbl[lv][a] % NODES;
      end
    end
    if (a == b) begin
      return FIELD_W'(a);
    end
    for (lv = LEVELS - 1; lv >= 0; lv--) begin
      pa = hop_tbl[lv][a] % NODES;
      pb = hop_tbl[lv][b] % NODES;
      if (pa != pb) begin
        a = pa;
        b = pb;
      end
    end
    return FIELD_W'(hop_tbl[0][a] % NODES);
  endfunction

  always @(posedge clk) begin : watch
    logic [FIELD_W-1:0] want;
    if (rst) begin
      lca_expect.delete();
      clear_shadow();
    end else begin
      if (done) begin
        answers_seen++;
        if (lca_expect.size() == 0) begin
          report_miss($sformatf("answer %0d: ancestor %0d with no query waiting",
                                answers_seen, ancestor));
        end else begin
          want = lca_expect.pop_front();
          if (ancestor !== want) begin
            report_miss($sformatf("answer %0d: ancestor %0d, expected %0d",
                                  answers_seen, ancestor, want));
          end
        end
      end
      if (start && !busy) begin
        case (func)
          FN_LOAD: begin
            hop_tbl[0][node % NODES] = FIELD_W'(parent % NODES);
            depth_mem[node % NODES] = depth;
          end
          FN_BUILD: rebuild_hops();
          FN_QUERY: lca_expect = {lca_expect, lca_of(node, other_node)};
          default: ;
        endcase
      end
    end
    pending = lca_expect.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench
  import bllca_pkg::*;
();

  localparam int NODES = DEF_NODES;
  localparam int LEVELS = DEF_LEVELS;
  localparam int ITEMS = 1900;
  // func code the block leaves alone
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  // longest query plus margin
  localparam int DRAIN_CYCLES = 7 * LEVELS + 24;
  localparam int FIELD_MAX = (1 << FIELD_W) - 1;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic [FUNC_W-1:0]  func;
  logic [FIELD_W-1:0] node;
  logic [FIELD_W-1:0] parent;
  logic [FIELD_W-1:0] depth;
  logic [FIELD_W-1:0] other_node;
  logic [FIELD_W-1:0] ancestor;
  logic               done;

  int mon_failures;
  int mon_pending;

  // transactions accepted, ignored func codes left out
  int items_sent;

  // current tree: its node ids (root first) and membership
  int tree_ids [$];
  bit in_tree [NODES];
  // depth handed out per node while a tree is planted
  int hop_of [NODES];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  binary_lifting_lca_engine_top #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .node       (node),
    .parent     (parent),
    .depth      (depth),
    .other_node (other_node),
    .ancestor   (ancestor),
    .done       (done)
  );

  lca_checker #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .node       (node),
    .parent     (parent),
    .depth      (depth),
    .other_node (other_node),
    .ancestor   (ancestor),
    .done       (done),
    .failures   (mon_failures),
    .pending    (mon_pending)
  );

  // one transaction: optional idle cycles, then start held until an edge sees busy low
  task automatic issue(input logic [FUNC_W-1:0] f, input int n, input int p, input int d,
                       input int o);
    int pct;
    // sender idles 9% first, then 73%, then never
    pct = (items_sent < ITEMS / 3) ? 9 : (items_sent < 2 * ITEMS / 3) ? 73 : 0;
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    func <= f;
    node <= FIELD_W'(n);
    parent <= FIELD_W'(p);
    depth <= FIELD_W'(d);
    other_node <= FIELD_W'(o);
    do @(posedge clk); while (busy);
    if (f != FN_UNUSED) begin
      items_sent++;
    end
  endtask

  // hold off until the block is idle and every answer is back
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (busy || mon_pending != 0);
    @(posedge clk);
  endtask

  // pick distinct ids, link each but the root to an earlier one, load them all, then build
  task automatic plant_tree(input int size);
    int id;
    int up;
    int dp;
    int j;
    in_tree = '{default: 1'b0};
    tree_ids.delete();
    while (tree_ids.size() < size) begin
      id = $urandom_range(NODES - 1);
      if (!in_tree[id]) begin
        in_tree[id] = 1'b1;
        tree_ids = {tree_ids, id};
      end
    end
    for (j = 0; j < size; j++) begin
      if (j == 0) begin
        // root names itself; now and then a nonzero depth
        up = tree_ids[0];
        dp = ($urandom_range(7) == 0) ? $urandom_range(FIELD_MAX) : 0;
      end else begin
        // mostly chains for deep lifts, some bushy branches
        up = ($urandom_range(2) == 0) ? tree_ids[$urandom_range(j - 1)] : tree_ids[j - 1];
        if ($urandom_range(7) == 0) begin
          dp = $urandom_range(FIELD_MAX);  // depth that disagrees with the links
        end else begin
          dp = (hop_of[up] < FIELD_MAX) ? hop_of[up] + 1 : FIELD_MAX;
        end
      end
      hop_of[tree_ids[j]] = dp;
      issue(FN_LOAD, tree_ids[j], up, dp, $urandom_range(FIELD_MAX));
    end
    issue(FN_BUILD, $urandom_range(FIELD_MAX), $urandom_range(FIELD_MAX),
          $urandom_range(FIELD_MAX), $urandom_range(FIELD_MAX));
  endtask

  // queries inside the current tree, mixed with relinks, stray loads and unused codes
  task automatic probe_tree(input int count);
    int k;
    int a;
    int b;
    int stray;
    for (k = 0; k < count; k++) begin
      a = tree_ids[$urandom_range(tree_ids.size() - 1)];
      b = tree_ids[$urandom_range(tree_ids.size() - 1)];
      case ($urandom_range(39))
        0, 1: issue(FN_QUERY, a, $urandom_range(FIELD_MAX), $urandom_range(FIELD_MAX), a);
        2, 3: begin
          // against the root, either order
          if ($urandom_range(1) == 0) begin
            issue(FN_QUERY, a, $urandom_range(FIELD_MAX), $urandom_range(FIELD_MAX),
                  tree_ids[0]);
          end else begin
            issue(FN_QUERY, tree_ids[0], $urandom_range(FIELD_MAX), $urandom_range(FIELD_MAX),
                  a);
          end
        end
        4: begin
          // relink inside the tree; upper levels stay stale until the next build
          issue(FN_LOAD, a, b, $urandom_range(FIELD_MAX), $urandom_range(FIELD_MAX));
        end
        5: begin
          // node outside the tree, never queried
          do stray = $urandom_range(NODES - 1); while (in_tree[stray]);
          issue(FN_LOAD, stray, $urandom_range(FIELD_MAX), $urandom_range(FIELD_MAX),
                $urandom_range(FIELD_MAX));
        end
        6: begin
          issue(FN_UNUSED, $urandom_range(FIELD_MAX), $urandom_range(FIELD_MAX),
                $urandom_range(FIELD_MAX), $urandom_range(FIELD_MAX));
        end
        7: begin
          // rare rebuild in the middle of a phase, after relinks
          if ($urandom_range(9) == 0) begin
            issue(FN_BUILD, a, b, $urandom_range(FIELD_MAX), $urandom_range(FIELD_MAX));
          end else begin
            issue(FN_QUERY, b, $urandom_range(FIELD_MAX), $urandom_range(FIELD_MAX), a);
          end
        end
        default: issue(FN_QUERY, a, $urandom_range(FIELD_MAX), $urandom_range(FIELD_MAX), b);
      endcase
    end
  endtask

  // run limit, several times the slowest legal run
  initial begin
    #60000000;
    $display("** binary_lifting_lca_engine_top: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int size;
    items_sent = 0;
    rst <= 1'b1;
    start <= 1'b0;
    func <= FN_LOAD;
    node <= '0;
    parent <= '0;
    depth <= '0;
    other_node <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: small tree over the extreme ids
    // 1023 root, 0 and 512 under it, 682 and 341 under 0
    issue(FN_LOAD, 1023, 1023, 0, 0);
    issue(FN_LOAD, 0, 1023, 1, FIELD_MAX);
    issue(FN_LOAD, 682, 0, 2, 341);
    issue(FN_LOAD, 341, 0, FIELD_MAX, 682);  // depth far beyond its real level
    issue(FN_LOAD, 512, 1023, 1, 0);
    issue(FN_UNUSED, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX);
    issue(FN_BUILD, 0, 0, 0, 0);
    issue(FN_QUERY, 0, 0, 0, 0);  // same node twice
    issue(FN_QUERY, 1023, FIELD_MAX, FIELD_MAX, 0);  // root with its child
    issue(FN_QUERY, 682, 0, 0, 341);
    issue(FN_QUERY, 341, FIELD_MAX, FIELD_MAX, 682);
    issue(FN_QUERY, 682, 0, 0, 512);  // different branches
    issue(FN_QUERY, 341, 0, 0, 1023);  // widest depth gap, lift stops at the root
    issue(FN_QUERY, 1023, 0, 0, 1023);
    issue(FN_UNUSED, 0, 0, 0, 0);
    issue(FN_LOAD, 0, 0, 0, 0);  // node 0 becomes a second root, table stale
    issue(FN_QUERY, 682, 0, 0, 512);
    issue(FN_QUERY, 341, 0, 0, 0);

    // random phases: new tree, build, then queries over it
    phase = 0;
    while (items_sent < ITEMS) begin
      wait_drained();
      size = (phase == 3) ? 300 : $urandom_range(2, 40);
      plant_tree(size);
      probe_tree($urandom_range(80, 140));
      phase++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mon_failures == 0 && mon_pending == 0) begin
      $display("** binary_lifting_lca_engine_top: PASSED **");
    end else begin
      if (mon_pending != 0) begin
        $display("%0d queries never answered", mon_pending);
      end
      $display("** binary_lifting_lca_engine_top: FAILED **");
    end
    $finish;
  end

endmodule
